/* sv/btpc_pkg.sv */
// btpc_pkg: shared types, micro-op codes and helpers for the barometer
// compensation block. No dependencies.
package btpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned StepW   = 5;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_DIV, OP_END,
    OP_M_UT, OP_TX1, OP_TSETUP, OP_TFIN,
    OP_B6, OP_M_B6B6, OP_SQ, OP_M_B2SQ, OP_X1, OP_M_AC2B6, OP_B3,
    OP_M_AC3B6, OP_X1B, OP_M_B1SQ, OP_X3, OP_M_B4, OP_B4, OP_M_B7,
    OP_PSETUP, OP_PQ, OP_M_PP, OP_M_3038, OP_X1C, OP_M_7357, OP_PFIN
  } op_e;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV, S_OUT} state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic fault;
  } dp_stat_t;

  // arithmetic right shift of a 32-bit word
  function automatic logic [31:0] asr32(logic [31:0] v, logic [4:0] sh);
    asr32 = 32'($signed(v) >>> sh);
  endfunction

  // micro-program: temperature (func 0) and pressure (func 1) sequences
  function automatic op_e prog(logic func, logic [StepW-1:0] step);
    op_e r;
    r = OP_END;
    if (!func) begin
      case (step)
        5'd0: r = OP_M_UT;
        5'd1: r = OP_TX1;
        5'd2: r = OP_TSETUP;
        5'd3: r = OP_DIV;
        5'd4: r = OP_TFIN;
        default: r = OP_END;
      endcase
    end else begin
      case (step)
        5'd0:  r = OP_B6;
        5'd1:  r = OP_M_B6B6;
        5'd2:  r = OP_SQ;
        5'd3:  r = OP_M_B2SQ;
        5'd4:  r = OP_X1;
        5'd5:  r = OP_M_AC2B6;
        5'd6:  r = OP_B3;
        5'd7:  r = OP_M_AC3B6;
        5'd8:  r = OP_X1B;
        5'd9:  r = OP_M_B1SQ;
        5'd10: r = OP_X3;
        5'd11: r = OP_M_B4;
        5'd12: r = OP_B4;
        5'd13: r = OP_M_B7;
        5'd14: r = OP_PSETUP;
        5'd15: r = OP_DIV;
        5'd16: r = OP_PQ;
        5'd17: r = OP_M_PP;
        5'd18: r = OP_M_3038;
        5'd19: r = OP_X1C;
        5'd20: r = OP_M_7357;
        5'd21: r = OP_PFIN;
        default: r = OP_END;
      endcase
    end
    return r;
  endfunction

endpackage

/* sv/btpc_if.sv */
// btpc_in_if / btpc_out_if: valid/ready channels of the compensation block
// no dependencies
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [18:0] raw_reading;
  modport source (output valid, func, raw_reading, input ready);
  modport sink   (input valid, func, raw_reading, output ready);
endinterface

interface btpc_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] compensated;
  logic               div_fault;
  modport source (output valid, kind, compensated, div_fault, input ready);
  modport sink   (input valid, kind, compensated, div_fault, output ready);
endinterface

/* sv/btpc_ctrl.sv */
// btpc_ctrl: sequencer stepping the micro-program and the divider
// depends on btpc_pkg
module btpc_ctrl import btpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [4:0]       cnt_q, cnt_d;
  op_e              cur_op;

  assign cur_op = prog(stat_i.func, step_q);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RUN;
          step_d  = '0;
        end
      end
      S_RUN: begin
        if (cur_op == OP_END) begin
          state_d = S_OUT;
        end else if (cur_op == OP_DIV) begin
          step_d  = step_q + 1'b1;
          cnt_d   = '0;
          state_d = stat_i.fault ? S_OUT : S_DIV;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd31) state_d = S_RUN;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.div_step = 1'b0;
    cmd_o.op     = OP_NOP;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_RUN: begin
        if (cur_op != OP_END && cur_op != OP_DIV) cmd_o.op = cur_op;
      end
      S_DIV:  cmd_o.div_step = 1'b1;
      S_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

/* sv/btpc_dp.sv */
// btpc_dp: configuration registers, multiplier, restoring divider and
// working registers of the compensation; depends on btpc_pkg
module btpc_dp import btpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_func_i,
  input  logic [18:0]        in_raw_i,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  output logic               kind_o,
  output logic [31:0]        res_o,
  output logic               fault_o
);

  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;
  logic [31:0] tt_q, tt_d;
  logic        func_q;
  logic [18:0] raw_q;
  logic [31:0] prod_q, prod_d, b6_q, b6_d, sq_q, sq_d, acc_q, acc_d;
  logic [31:0] b3_q, b3_d, b4_q, b4_d, p_q, p_d, res_q, res_d;
  logic [31:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic        fault_q, fault_d, neg_q, neg_d, shl_q, shl_d;

  // calibration words: AC4, AC5 and AC6 zero-extended, the others sign-extended
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = 32'($signed(ac12_q[31:16]));
  assign ac2 = 32'($signed(ac12_q[15:0]));
  assign ac3 = 32'($signed(ac34_q[31:16]));
  assign ac4 = {16'd0, ac34_q[15:0]};
  assign ac5 = {16'd0, ac56_q[31:16]};
  assign ac6 = {16'd0, ac56_q[15:0]};
  assign b1  = 32'($signed(b12_q[31:16]));
  assign b2  = 32'($signed(b12_q[15:0]));
  assign mc  = 32'($signed(mcmd_q[31:16]));
  assign md  = 32'($signed(mcmd_q[15:0]));

  // configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0; ac34_q <= '0; ac56_q <= '0; b12_q <= '0; mcmd_q <= '0;
      oss_q  <= '0;
      tt_q   <= '0;
      fault_q <= 1'b0;
      func_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_AC1_AC2: ac12_q <= cfg_data_i;
          REG_AC3_AC4: ac34_q <= cfg_data_i;
          REG_AC5_AC6: ac56_q <= cfg_data_i;
          REG_B1_B2:   b12_q  <= cfg_data_i;
          REG_MC_MD:   mcmd_q <= cfg_data_i;
          REG_OSS:     oss_q  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      tt_q    <= tt_d;
      fault_q <= fault_d;
      if (cmd_i.load) func_q <= in_func_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) raw_q <= in_raw_i;
    prod_q <= prod_d; b6_q <= b6_d; sq_q <= sq_d; acc_q <= acc_d;
    b3_q <= b3_d; b4_q <= b4_d; p_q <= p_d; res_q <= res_d;
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
    neg_q <= neg_d; shl_q <= shl_d;
  end

  // operation decode
  logic [31:0] mul_a, mul_b, t0, t1, num, den, quo_s, p8;
  logic [32:0] rem_sh, trial;
  always_comb begin
    prod_d = prod_q; b6_d = b6_q; sq_d = sq_q; acc_d = acc_q;
    b3_d = b3_q; b4_d = b4_q; p_d = p_q; res_d = res_q;
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q;
    neg_d = neg_q; shl_d = shl_q; tt_d = tt_q; fault_d = fault_q;
    mul_a = '0; mul_b = '0; t0 = '0; t1 = '0;
    num = 32'(mc << 11);
    den = acc_q + md;
    p8  = asr32(p_q, 5'd8);
    quo_s = neg_q ? 32'(-quo_q) : quo_q;
    rem_sh = {rem_q, quo_q[31]};
    trial  = rem_sh - {1'b0, dvs_q};

    // one multiplier operand pair per operation
    case (cmd_i.op)
      OP_M_UT:    begin mul_a = {13'd0, raw_q} & 32'h0000FFFF; mul_a = mul_a - ac6;
                        mul_b = ac5; end
      OP_M_B6B6:  begin mul_a = b6_q; mul_b = b6_q; end
      OP_M_B2SQ:  begin mul_a = b2;   mul_b = sq_q; end
      OP_M_AC2B6: begin mul_a = ac2;  mul_b = b6_q; end
      OP_M_AC3B6: begin mul_a = ac3;  mul_b = b6_q; end
      OP_M_B1SQ:  begin mul_a = b1;   mul_b = sq_q; end
      OP_M_B4:    begin mul_a = ac4;  mul_b = acc_q + 32'd32768; end
      OP_M_B7:    begin mul_a = {13'd0, raw_q} - b3_q;
                        mul_b = 32'd50000 >> oss_q; end
      OP_M_PP:    begin mul_a = p8;   mul_b = p8; end
      OP_M_3038:  begin mul_a = prod_q; mul_b = 32'd3038; end
      OP_M_7357:  begin mul_a = 32'(-32'sd7357); mul_b = p_q; end
      default: ;
    endcase

    case (cmd_i.op)
      OP_M_UT, OP_M_B6B6, OP_M_B2SQ, OP_M_AC2B6, OP_M_AC3B6, OP_M_B1SQ,
      OP_M_B4, OP_M_B7, OP_M_PP, OP_M_3038, OP_M_7357:
        prod_d = 32'(mul_a * mul_b);
      // temperature
      OP_TX1: acc_d = asr32(prod_q, 5'd15);
      OP_TSETUP: begin
        if (den == '0) begin
          fault_d = 1'b1;
        end else begin
          neg_d = num[31] ^ den[31];
          quo_d = num[31] ? 32'(-num) : num;
          dvs_d = den[31] ? 32'(-den) : den;
          rem_d = '0;
        end
      end
      OP_TFIN: begin
        t0    = acc_q + quo_s;
        tt_d  = t0;
        res_d = asr32(t0 + 32'd8, 5'd4);
      end
      // pressure
      OP_B6: b6_d = tt_q - 32'd4000;
      OP_SQ: sq_d = asr32(prod_q, 5'd12);
      OP_X1: acc_d = asr32(prod_q, 5'd11);
      OP_B3: begin
        t0   = acc_q + asr32(prod_q, 5'd11);
        t1   = 32'(((ac1 << 2) + t0) << oss_q);
        b3_d = asr32(t1 + 32'd2, 5'd2);
      end
      OP_X1B: acc_d = asr32(prod_q, 5'd13);
      OP_X3:  acc_d = asr32(acc_q + asr32(prod_q, 5'd16) + 32'd2, 5'd2);
      OP_B4:  b4_d = prod_q >> 15;
      OP_PSETUP: begin
        if (b4_q == '0) begin
          fault_d = 1'b1;
        end else begin
          neg_d = 1'b0;
          shl_d = prod_q[31];
          quo_d = prod_q[31] ? prod_q : {prod_q[30:0], 1'b0};
          dvs_d = b4_q;
          rem_d = '0;
        end
      end
      OP_PQ:  p_d = shl_q ? {quo_q[30:0], 1'b0} : quo_q;
      OP_X1C: acc_d = asr32(prod_q, 5'd16);
      OP_PFIN: res_d = p_q + asr32(acc_q + asr32(prod_q, 5'd16) + 32'd3791, 5'd4);
      default: ;
    endcase

    // one restoring divide step
    if (cmd_i.div_step) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
    end

    if (cmd_i.load) begin
      fault_d = 1'b0;
      res_d   = '0;
    end
  end

  assign stat_o.func  = func_q;
  assign stat_o.fault = fault_q;
  assign kind_o  = func_q;
  assign res_o   = res_q;
  assign fault_o = fault_q;

endmodule

/* sv/baro_temp_pressure_compensation.sv */
// baro_temp_pressure_compensation: top level, sequencer plus datapath
// depends on btpc_pkg, btpc_if, btpc_ctrl, btpc_dp
//
//  channel  | dir | payload
//  in_if    | in  | func, raw_reading
//  out_if   | out | kind, compensated, div_fault
//  cfg_*    | in  | write enable, index, 32-bit data
//
// time from one accept to the next, for either kind of item, is
// set by the restoring divider plus one step per shared 32x32 product
// one item at a time: in_if.ready is high only while idle
// result held on out_if until taken, so each stall delays the next accept
// a zero divisor sets div_fault and ends the item early, skipping the divider
// asynchronous active-low reset clears calibration, oversampling and B5
module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  btpc_in_if.sink            in_if,
  btpc_out_if.source         out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] res;

  btpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  btpc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_func_i  (in_if.func),
    .in_raw_i   (in_if.raw_reading),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .kind_o     (out_if.kind),
    .res_o      (res),
    .fault_o    (out_if.div_fault)
  );

  assign out_if.compensated = $signed(res);

endmodule
